// File: hw/rtl/ssep_pkg.sv
// ssep_pkg: shared types and constants of the sound sequence event parser
// used by every module under hw/rtl; no dependencies of its own

package ssep_pkg;

    // default width of the delay accumulator
    localparam int DELAY_WIDTH_DEF = 28;
    localparam int DELAY_INIT      = 96;

    // result kinds, carried on m_tuser
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_TEMPO   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // command high nibbles
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_POLY     = 4'hA;
    localparam logic [3:0] NIB_CTRL     = 4'hB;
    localparam logic [3:0] NIB_PROG     = 4'hC;
    localparam logic [3:0] NIB_CHAN     = 4'hD;
    localparam logic [3:0] NIB_BEND     = 4'hE;
    localparam logic [3:0] NIB_SYS      = 4'hF;

    // system commands and fixed byte values
    localparam logic [7:0] CMD_SKIP_A   = 8'hF1;
    localparam logic [7:0] CMD_TEMPO    = 8'hF2;
    localparam logic [7:0] CMD_SKIP_B   = 8'hF3;
    localparam logic [7:0] DELTA_EXT    = 8'hF8;
    localparam logic [7:0] CMD_END      = 8'hFF;
    localparam logic [7:0] NOTE_OFF_VEL = 8'h40;
    localparam logic [7:0] MOD_CTRL     = 8'h01;
    localparam logic [7:0] META_STATUS  = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] TEMPO_LEN    = 8'h03;
    localparam logic [7:0] META_END     = 8'h2F;

    // tempo division: 60000000 / t, one quotient bit per step
    localparam int          DIV_STEPS      = 26;
    localparam logic [25:0] TEMPO_DIVIDEND = 26'd60000000;
    localparam logic [23:0] TEMPO_SAT      = 24'hFFFFFF;

    // what one accepted item asks the sequencer to emit
    typedef struct packed {
        logic       has_event;
        logic       has_end;
        logic       bad;
        logic [1:0] kind;
        logic [7:0] status;
        logic [7:0] d1;
        logic [7:0] d2;
        logic       is_tempo;
        logic [7:0] tempo_byte;
    } plan_t;

endpackage

// File: hw/rtl/ssep_divider.sv
// ssep_divider: restoring divider for the tempo command, 60000000 / t
// one quotient bit per cycle; depends on ssep_pkg

module ssep_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [23:0] quotient
);
    import ssep_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(DIV_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [7:0]           rem_reg, rem_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic [7:0]           div_reg, div_next;
    logic [8:0]           trial;
    logic [8:0]           diff;
    logic                 fits;

    // one shift, compare and subtract step
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_STEPS-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = TEMPO_DIVIDEND;
            div_next   = divisor;
        end else if (busy_reg) begin
            rem_next   = fits ? diff[7:0] : trial[7:0];
            quo_next   = {quo_reg[DIV_STEPS-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[23:0];

endmodule

// File: hw/rtl/ssep_parser.sv
// ssep_parser: byte-level parse state, delta accumulation and command decode
// depends on ssep_pkg; produces the plan for each accepted item

module ssep_parser #(
    parameter int DELAY_WIDTH = ssep_pkg::DELAY_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output ssep_pkg::plan_t        plan,
    output logic [DELAY_WIDTH-1:0] ev_delay,
    output logic [DELAY_WIDTH-1:0] end_delay
);
    import ssep_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_DELTA  = 3'd1;
    localparam logic [2:0] PH_CMD    = 3'd2;
    localparam logic [2:0] PH_ONE    = 3'd3;
    localparam logic [2:0] PH_PAIR_A = 3'd4;
    localparam logic [2:0] PH_PAIR_B = 3'd5;
    localparam logic [2:0] PH_SKIP_2 = 3'd6;
    localparam logic [2:0] PH_SKIP_1 = 3'd7;

    localparam logic [DELAY_WIDTH-1:0] DELAY_MAX   = '1;
    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = DELAY_WIDTH'(DELAY_INIT);

    logic [2:0]             phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0] pending_reg, pending_next;
    logic [7:0]             cmd_reg, cmd_next;
    logic [7:0]             data_reg, data_next;
    logic                   ended_reg, ended_next;

    logic                   add_en;
    logic                   end_req;
    logic                   bad_req;
    logic [DELAY_WIDTH:0]   sum;
    logic [DELAY_WIDTH-1:0] acc;
    plan_t                  pl;

    // saturating delta add
    always_comb begin
        sum = {1'b0, pending_reg} + (DELAY_WIDTH + 1)'(in_byte);
    end

    // decode of the current byte against the parse phase
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        add_en     = 1'b0;
        end_req    = 1'b0;
        bad_req    = 1'b0;
        pl         = '0;

        case (phase_reg)
            PH_HEADER: phase_next = PH_DELTA;
            PH_DELTA: begin
                add_en     = 1'b1;
                phase_next = (in_byte == DELTA_EXT) ? PH_DELTA : PH_CMD;
            end
            PH_CMD: begin
                cmd_next = in_byte;
                case (in_byte[7:4])
                    NIB_NOTE_OFF, NIB_POLY, NIB_PROG, NIB_CHAN, NIB_BEND:
                        phase_next = PH_ONE;
                    NIB_NOTE_ON, NIB_CTRL:
                        phase_next = PH_PAIR_A;
                    NIB_SYS: begin
                        if (in_byte == CMD_SKIP_A || in_byte == CMD_SKIP_B) begin
                            phase_next = PH_SKIP_2;
                        end else if (in_byte == CMD_TEMPO) begin
                            phase_next = PH_ONE;
                        end else if (in_byte == DELTA_EXT) begin
                            add_en     = 1'b1;
                            phase_next = PH_DELTA;
                        end else if (in_byte == CMD_END) begin
                            end_req = 1'b1;
                        end else begin
                            end_req = 1'b1;
                            bad_req = 1'b1;
                        end
                    end
                    default: begin
                        end_req = 1'b1;
                        bad_req = 1'b1;
                    end
                endcase
            end
            PH_ONE: begin
                phase_next   = PH_DELTA;
                pl.has_event = 1'b1;
                pl.kind      = KIND_CHANNEL;
                pl.status    = cmd_reg;
                case (cmd_reg[7:4])
                    NIB_NOTE_OFF: begin
                        pl.d1 = in_byte;
                        pl.d2 = NOTE_OFF_VEL;
                    end
                    NIB_POLY: begin
                        pl.status = {NIB_CTRL, cmd_reg[3:0]};
                        pl.d1     = MOD_CTRL;
                        pl.d2     = in_byte;
                    end
                    NIB_BEND: pl.d2 = in_byte;
                    NIB_PROG, NIB_CHAN: pl.d1 = in_byte;
                    NIB_SYS: begin
                        pl.kind       = KIND_TEMPO;
                        pl.status     = META_STATUS;
                        pl.d1         = META_TEMPO;
                        pl.d2         = TEMPO_LEN;
                        pl.is_tempo   = 1'b1;
                        pl.tempo_byte = in_byte;
                    end
                    default: pl.has_event = 1'b0;
                endcase
            end
            PH_PAIR_A: begin
                data_next  = in_byte;
                phase_next = PH_PAIR_B;
            end
            PH_PAIR_B: begin
                phase_next   = PH_DELTA;
                pl.has_event = 1'b1;
                pl.kind      = KIND_CHANNEL;
                pl.status    = cmd_reg;
                pl.d1        = data_reg;
                pl.d2        = in_byte;
            end
            PH_SKIP_2: phase_next = PH_SKIP_1;
            default:   phase_next = PH_DELTA;
        endcase

        pl.has_end = end_req | in_last;
        pl.bad     = bad_req;

        // a finished track produces nothing more
        if (ended_reg) begin
            pl = '0;
        end
    end

    // delay bookkeeping
    always_comb begin
        if (add_en) begin
            acc = sum[DELAY_WIDTH] ? DELAY_MAX : sum[DELAY_WIDTH-1:0];
        end else begin
            acc = pending_reg;
        end
        ev_delay     = pending_reg;
        end_delay    = pl.has_event ? '0 : acc;
        pending_next = (pl.has_event || pl.has_end) ? '0 : acc;
        ended_next   = ended_reg | pl.has_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            pending_reg <= DELAY_RESET;
            cmd_reg     <= '0;
            data_reg    <= '0;
            ended_reg   <= 1'b0;
        end else if (accept && !ended_reg) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            cmd_reg     <= cmd_next;
            data_reg    <= data_next;
            ended_reg   <= ended_next;
        end
    end

    assign plan = pl;

endmodule

// File: hw/rtl/sound_sequence_event_parser_core.sv
// sound_sequence_event_parser_core: top level, sequencer and output register
// instantiates ssep_parser and ssep_divider; depends on ssep_pkg
//
//  channel | ports           | tdata fields (lsb first)                      | side
//  --------+-----------------+-----------------------------------------------+-----
//  input   | s_tvalid/tready | stream_byte; tlast = stream_last              | in
//  result  | m_tvalid/tready | event_delay, status_byte, first_data,         | out
//          |                 | second_data, tempo_usec, bad_command;         |
//          |                 | tuser = event_kind, tlast = last_result       |
//
// one item is taken, then its results go out one per cycle through the output register
// while m_tready is high; an item with no results leaves the sequencer idle, and a tempo
// data byte other than zero first runs the bit-serial divider
// s_tready is low while results are pending or the output register is full
// reset is synchronous; the first byte after reset is taken as the header

module sound_sequence_event_parser_core #(
    parameter int DELAY_WIDTH = ssep_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,  // stream_byte
    input  logic                                   s_tlast,  // stream_last
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // event_delay, status_byte, first_data, second_data, tempo_usec, bad_command
    output logic [((DELAY_WIDTH+49+7)/8)*8-1:0]    m_tdata,
    output logic [1:0]                             m_tuser,  // event_kind
    output logic                                   m_tlast   // last_result
);
    import ssep_pkg::*;

    localparam int PAY_W   = DELAY_WIDTH + 49;
    localparam int TDATA_W = ((DELAY_WIDTH + 49 + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_EVENT = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic                   accept;
    plan_t                  plan;
    logic [DELAY_WIDTH-1:0] ev_delay;
    logic [DELAY_WIDTH-1:0] end_delay;
    logic                   div_start;
    logic                   div_done;
    logic [23:0]            div_quo;

    logic [1:0]             state_reg, state_next;
    plan_t                  plan_reg;
    logic [DELAY_WIDTH-1:0] ev_delay_reg;
    logic [DELAY_WIDTH-1:0] end_delay_reg;
    logic [23:0]            tempo_reg, tempo_next;

    logic                   out_valid_reg, out_valid_next;
    logic [PAY_W-1:0]       out_data_reg, out_data_next;
    logic [1:0]             out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    ssep_parser #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .plan      (plan),
        .ev_delay  (ev_delay),
        .end_delay (end_delay)
    );

    // divider runs only for a nonzero tempo byte
    assign div_start = accept && plan.has_event && plan.is_tempo && (plan.tempo_byte != 8'd0);

    ssep_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (plan.tempo_byte),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result sequencer
    always_comb begin
        state_next     = state_reg;
        tempo_next     = tempo_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    tempo_next = plan.is_tempo ? TEMPO_SAT : 24'd0;
                    if (div_start) begin
                        state_next = ST_DIV;
                    end else if (plan.has_event) begin
                        state_next = ST_EVENT;
                    end else if (plan.has_end) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    tempo_next = div_quo;
                    state_next = ST_EVENT;
                end
            end
            ST_EVENT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = plan_reg.kind;
                    out_last_next  = !plan_reg.has_end;
                    out_data_next  = {1'b0, tempo_reg, plan_reg.d2, plan_reg.d1,
                                      plan_reg.status, ev_delay_reg};
                    state_next     = plan_reg.has_end ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_END;
                    out_last_next  = 1'b1;
                    out_data_next  = {plan_reg.bad, 24'd0, 8'd0, META_END,
                                      META_STATUS, end_delay_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        if (accept) begin
            plan_reg      <= plan;
            ev_delay_reg  <= ev_delay;
            end_delay_reg <= end_delay;
        end
        tempo_reg    <= tempo_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/ssep_checker.sv
// ssep_checker: port-level checks of the parser core, bound to the top level
// depends on ssep_pkg and sound_sequence_event_parser_core

module ssep_checker #(
    parameter int DELAY_WIDTH = ssep_pkg::DELAY_WIDTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [7:0]                          s_tdata,
    input logic                                s_tlast,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((DELAY_WIDTH+49+7)/8)*8-1:0] m_tdata,
    input logic [1:0]                          m_tuser,
    input logic                                m_tlast
);
    import ssep_pkg::*;

    // output register is empty right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item at a time: no input taken while a result waits
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // end of track closes its item's run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tlast)
        else $error("end of track without last flag");

    // nothing follows a delivered end of track in the next cycle
    a_end_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_END |=> !m_tvalid)
        else $error("result right after end of track");

endmodule

bind sound_sequence_event_parser_core ssep_checker #(
    .DELAY_WIDTH(DELAY_WIDTH)
) u_ssep_checker (.*);
